// ----- rtl/core/cld_pkg.sv -----
// ----------------------------------------------------------------------------
// cld_pkg - console line discipline shared types and constants
// Character codes, pointer widths and the item and result word layouts.
// ----------------------------------------------------------------------------
package cld_pkg;

  localparam int unsigned BufDepth = 128;
  localparam int unsigned IdxW     = $clog2(BufDepth);
  localparam int unsigned PosW     = IdxW + 1;
  localparam int unsigned QDepth   = 2;

  localparam logic [7:0] ChDel  = 8'h7f;
  localparam logic [7:0] ChCr   = 8'h0d;
  localparam logic [7:0] ChLf   = 8'h0a;
  localparam logic [7:0] CtrlD  = 8'h04;
  localparam logic [7:0] CtrlU  = 8'h15;
  localparam logic [7:0] CtrlH  = 8'h08;
  localparam logic [7:0] CtrlP  = 8'h10;
  localparam logic [7:0] ChNul  = 8'h00;

  localparam logic RegEcho  = 1'b0;
  localparam logic RegCanon = 1'b1;

  // operation classes decided by the front end
  typedef enum logic [2:0] {
    OpNone, OpDump, OpKill, OpErase, OpStore, OpRead
  } op_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] char_in;
    logic       first_of_read;
  } item_t;

  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_char;
    logic [7:0] erase_count;
    logic       dump_request;
    logic       dropped;
    logic       line_ready;
    logic       read_valid;
    logic [7:0] read_char;
    logic       read_done;
    logic       read_eof;
    logic       read_empty;
  } result_t;

  // classified word passed through the queue
  typedef struct packed {
    op_e        op;
    logic [7:0] ch;
    logic       first;
    logic       echo;
    logic       canon;
  } cmd_t;

endpackage

// ----- rtl/core/cld_ram.sv -----
// ----------------------------------------------------------------------------
// cld_ram - generic single port ram
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module cld_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write or registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ----- rtl/core/cld_front.sv -----
// ----------------------------------------------------------------------------
// cld_front - command intake and classification
// Holds the mode registers, classifies each word and queues it.
// ----------------------------------------------------------------------------
module cld_front import cld_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  output logic  busy,
  input  item_t item_i,
  input  logic  cfg_we_i,
  input  logic  cfg_idx_i,
  input  logic  cfg_data_i,
  output logic  cmd_valid_o,
  output cmd_t  cmd_o,
  input  logic  cmd_pop_i
);

  logic echo_q, canon_q;
  cmd_t q_q [QDepth];
  logic [$clog2(QDepth):0] cnt_q, cnt_d;
  logic [$clog2(QDepth)-1:0] rd_q, wr_q;
  cmd_t cls;
  logic push;
  logic [7:0] c;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_q  <= 1'b1;
      canon_q <= 1'b1;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegEcho) echo_q <= cfg_data_i;
      else canon_q <= cfg_data_i;
    end
  end

  // classify the incoming word
  always_comb begin
    c = (item_i.char_in == ChCr && canon_q) ? ChLf : item_i.char_in;
    cls.ch    = c;
    cls.first = item_i.first_of_read;
    cls.echo  = echo_q;
    cls.canon = canon_q;
    if (item_i.mode) cls.op = OpRead;
    else if (c == ChNul) cls.op = OpNone;
    else if (!canon_q) cls.op = OpStore;
    else if (c == CtrlP) cls.op = OpDump;
    else if (c == CtrlU) cls.op = OpKill;
    else if (c == CtrlH || c == ChDel) cls.op = OpErase;
    else cls.op = OpStore;
  end

  assign busy        = (cnt_q == QDepth[$clog2(QDepth):0]);
  assign push        = start && !busy;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !cmd_pop_i) cnt_d = cnt_q + 1'b1;
    else if (!push && cmd_pop_i) cnt_d = cnt_q - 1'b1;
  end

  // queue pointers, wrapping over a power of two depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
      wr_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_q <= wr_q + 1'b1;
      if (cmd_pop_i) rd_q <= rd_q + 1'b1;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) q_q[wr_q] <= cls;
  end

endmodule

// ----- rtl/core/cld_back.sv -----
// ----------------------------------------------------------------------------
// cld_back - ring buffer executor
// Carries out stores, erasures, kills and reads against the line store.
// ----------------------------------------------------------------------------
module cld_back import cld_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    cmd_valid_i,
  input  cmd_t    cmd_i,
  output logic    cmd_pop_o,
  output logic    res_valid_o,
  output result_t res_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StKill = 2'd1;
  localparam logic [1:0] StRead = 2'd2;

  logic [1:0]    st_q, st_d;
  logic [PosW-1:0] rp_q, rp_d, cp_q, cp_d, ep_q, ep_d;
  logic [7:0]    cnt_q, cnt_d;
  result_t       res_d;
  logic          rv_d;
  logic          we;
  logic [IdxW-1:0] addr;
  logic [7:0]    rdata;
  logic [PosW-1:0] fill, ep_n;

  cld_ram #(.Width(8), .Depth(BufDepth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(cmd_i.ch),
    .rdata_o(rdata)
  );

  assign fill = ep_q - rp_q;
  assign ep_n = ep_q + 1'b1;

  // sequencer: one step per cycle, kill walks back one byte a step
  always_comb begin
    st_d = st_q; rp_d = rp_q; cp_d = cp_q; ep_d = ep_q; cnt_d = cnt_q;
    res_d = '0; rv_d = 1'b0; we = 1'b0; cmd_pop_o = 1'b0;
    addr = ep_q[IdxW-1:0];
    case (st_q)
      StIdle: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            OpRead: begin
              if (rp_q == cp_q) begin
                res_d.read_empty = 1'b1; rv_d = 1'b1; cmd_pop_o = 1'b1;
              end else begin
                addr = rp_q[IdxW-1:0];
                st_d = StRead;
              end
            end
            OpKill: begin
              cnt_d = '0;
              if (ep_q == cp_q) begin
                rv_d = 1'b1; cmd_pop_o = 1'b1;
              end else begin
                addr = IdxW'(ep_q - 1'b1);
                st_d = StKill;
              end
            end
            OpErase: begin
              if (ep_q != cp_q) begin
                ep_d = ep_q - 1'b1;
                res_d.erase_count = {7'd0, cmd_i.echo};
              end
              rv_d = 1'b1; cmd_pop_o = 1'b1;
            end
            OpDump: begin
              res_d.dump_request = 1'b1; rv_d = 1'b1; cmd_pop_o = 1'b1;
            end
            OpStore: begin
              if (fill >= PosW'(BufDepth)) begin
                res_d.dropped = 1'b1;
              end else begin
                we = 1'b1;
                ep_d = ep_n;
                if (cmd_i.echo && cmd_i.ch != CtrlD) begin
                  res_d.echo_valid = 1'b1;
                  res_d.echo_char  = cmd_i.ch;
                end
                if (!cmd_i.canon || cmd_i.ch == ChLf || cmd_i.ch == CtrlD ||
                    (ep_n - rp_q) == PosW'(BufDepth)) begin
                  cp_d = ep_n;
                  res_d.line_ready = 1'b1;
                end
              end
              rv_d = 1'b1; cmd_pop_o = 1'b1;
            end
            default: begin
              rv_d = 1'b1; cmd_pop_o = 1'b1;
            end
          endcase
        end
      end
      StKill: begin
        // rdata holds the byte just before edit position
        if (rdata == ChLf) begin
          res_d.erase_count = cmd_i.echo ? cnt_q : 8'd0;
          rv_d = 1'b1; cmd_pop_o = 1'b1; st_d = StIdle;
        end else begin
          ep_d  = ep_q - 1'b1;
          cnt_d = cnt_q + 1'b1;
          if (ep_d == cp_q) begin
            res_d.erase_count = cmd_i.echo ? cnt_d : 8'd0;
            rv_d = 1'b1; cmd_pop_o = 1'b1; st_d = StIdle;
          end else begin
            addr = IdxW'(ep_d - 1'b1);
          end
        end
      end
      StRead: begin
        if (rdata == CtrlD && cmd_i.canon) begin
          if (cmd_i.first) rp_d = rp_q + 1'b1;
          res_d.read_done = 1'b1;
          res_d.read_eof  = 1'b1;
        end else begin
          rp_d = rp_q + 1'b1;
          res_d.read_valid = 1'b1;
          res_d.read_char  = rdata;
          res_d.read_done  = (rdata == ChLf) || !cmd_i.canon;
        end
        rv_d = 1'b1; cmd_pop_o = 1'b1; st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  // state and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; rp_q <= '0; cp_q <= '0; ep_q <= '0; cnt_q <= '0;
      res_valid_o <= 1'b0;
    end else begin
      st_q <= st_d; rp_q <= rp_d; cp_q <= cp_d; ep_q <= ep_d; cnt_q <= cnt_d;
      res_valid_o <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_o <= res_d;
  end

endmodule

// ----- rtl/core/console_line_discipline.sv -----
// ----------------------------------------------------------------------------
// console_line_discipline - terminal input line editor
// Canonical or raw line editing over a ring buffer with echo reporting.
// ----------------------------------------------------------------------------
// Usage: drive item_i and raise start; the word is taken at an edge where
// start is high and busy is low. mode 0 delivers a received character,
// mode 1 asks for one byte from committed data. Each word gives exactly one
// result on result_o, flagged by done_o for a single cycle; the receiver
// cannot hold results off.
// Path: stores, erasures and dump requests pass the queue, the executor
// and the result register; reads add one line store read. Ctrl-U walks
// back one byte per cycle until it meets a newline or the commit point.
// Throughput: one word every cycle for stores and erasures while the
// executor is idle; a read or a Ctrl-U holds the executor. A two entry
// queue between intake and executor absorbs the difference; busy is high
// while it is full. Config: cfg_we_i writes register cfg_idx_i (0 echo,
// 1 canonical); the user must write only while idle, the block does not
// enforce it. Reset empties the buffer and sets echo and canonical mode.
// ----------------------------------------------------------------------------
module console_line_discipline import cld_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  item_t   item_i,
  input  logic    cfg_we_i,
  input  logic    cfg_idx_i,
  input  logic    cfg_data_i,
  output logic    done_o,
  output result_t result_o
);

  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  cld_front u_front (
    .clk_i, .rst_ni, .start, .busy, .item_i, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_pop_i(cmd_pop)
  );

  cld_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_pop_o(cmd_pop),
    .res_valid_o(done_o), .res_o(result_o)
  );

endmodule
